FILE: src/ghp_pkg.sv
// Shared types and constants of the generational handle pool.
`timescale 1ns / 1ps
package ghp_pkg;

  localparam int CAPACITY = 256;
  localparam int IDX_W    = 8;
  localparam int CNT_W    = 9;
  localparam int GEN_W    = 32;

  localparam logic [GEN_W-1:0] GEN_RESET = GEN_W'(1);
  localparam logic [GEN_W-1:0] GEN_FRESH = GEN_W'(2);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CAPACITY);

  typedef enum logic [1:0] {
    REQ_ALLOC    = 2'd0,
    REQ_REMOVE   = 2'd1,
    REQ_VALIDATE = 2'd2,
    REQ_RESET    = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_INVALID = 2'd2
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic load_req;
    logic commit;
    logic walk_step;
    logic walk_done;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_reset;
    logic walk_end;
  } dp_status_t;

endpackage

FILE: src/generational_handle_pool.sv
// Top level of the generational handle pool: controller plus datapath.
`timescale 1ns / 1ps
// Handle allocator over a table of 256 slots. A request allocates a handle, removes or
// validates a presented handle (index, slot generation, pool generation), or resets the
// pool; every request returns exactly one result. Allocate, remove and validate read the
// slot tables into registers when the request is accepted, then check the handle and write
// the slot back, where the request changes it, when the result is committed. A pool reset
// walks the used slots one per cycle through the single write port of the slot tables.
// A new request is taken once the previous one has been committed to the result register;
// the result then waits there until it is taken.
module generational_handle_pool (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  req_type,
  input  logic [7:0]  handle_index,
  input  logic [31:0] handle_generation,
  input  logic [31:0] handle_pool_generation,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_index,
  output logic [31:0] out_generation,
  output logic [31:0] out_pool_generation,
  output logic        handle_ok,
  output logic [1:0]  status
);
  import ghp_pkg::*;

  // command and status between the two halves
  ctl_cmd_t   cmd;
  dp_status_t dp_stat;

  // sequence each request: read, commit or walk, then hold the result
  ghp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .dp_stat   (dp_stat),
    .cmd       (cmd)
  );

  // slot tables, free list, generations and result register
  ghp_datapath u_datapath (
    .clk                    (clk),
    .rst                    (rst),
    .cmd                    (cmd),
    .dp_stat                (dp_stat),
    .req_type               (req_type),
    .handle_index           (handle_index),
    .handle_generation      (handle_generation),
    .handle_pool_generation (handle_pool_generation),
    .out_index              (out_index),
    .out_generation         (out_generation),
    .out_pool_generation    (out_pool_generation),
    .handle_ok              (handle_ok),
    .status                 (status)
  );

endmodule

FILE: src/ghp_ctrl.sv
// Controller state machine of the generational handle pool.
`timescale 1ns / 1ps
module ghp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  ghp_pkg::dp_status_t dp_stat,
  output ghp_pkg::ctl_cmd_t   cmd
);
  import ghp_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WALK
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE) && !rst;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.load_req = 1'b1;
          state_next   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (dp_stat.is_reset) begin
          state_next = S_WALK;
        end else if (out_free) begin
          cmd.commit = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (!dp_stat.walk_end) begin
          cmd.walk_step = 1'b1;
        end else if (out_free) begin
          cmd.walk_done = 1'b1;
          state_next    = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.commit || cmd.walk_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: src/ghp_datapath.sv
// Datapath of the generational handle pool: slot tables, pool registers, result register.
`timescale 1ns / 1ps
module ghp_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  ghp_pkg::ctl_cmd_t               cmd,
  output ghp_pkg::dp_status_t             dp_stat,
  input  logic [1:0]                      req_type,
  input  logic [ghp_pkg::IDX_W-1:0]       handle_index,
  input  logic [ghp_pkg::GEN_W-1:0]       handle_generation,
  input  logic [ghp_pkg::GEN_W-1:0]       handle_pool_generation,
  output logic [ghp_pkg::IDX_W-1:0]       out_index,
  output logic [ghp_pkg::GEN_W-1:0]       out_generation,
  output logic [ghp_pkg::GEN_W-1:0]       out_pool_generation,
  output logic                            handle_ok,
  output logic [1:0]                      status
);
  import ghp_pkg::*;

  // slot tables
  logic [GEN_W-1:0] gen_mem  [CAPACITY];
  logic [CNT_W-1:0] link_mem [CAPACITY];
  logic [CAPACITY-1:0] slot_active;
  logic [CAPACITY-1:0] gen_written;

  // pool registers
  logic [CNT_W-1:0] free_head;
  logic [CNT_W-1:0] high_water;
  logic [GEN_W-1:0] pool_gen;
  logic [CNT_W-1:0] walk_cnt;

  // held request and registered slot read
  req_t             req_q;
  logic [IDX_W-1:0] idx_q;
  logic [GEN_W-1:0] gen_q;
  logic [GEN_W-1:0] pgen_q;
  logic [GEN_W-1:0] rd_gen_raw;
  logic             rd_gen_written;
  logic [CNT_W-1:0] rd_link;
  logic             rd_active;

  logic [IDX_W-1:0] rd_addr;
  logic [GEN_W-1:0] rd_gen;
  logic             valid_c;
  logic             is_new;
  logic             full;

  logic             gen_we;
  logic [IDX_W-1:0] gen_wa;
  logic [GEN_W-1:0] gen_wd;
  logic             link_we;
  logic [IDX_W-1:0] link_wa;
  logic [CNT_W-1:0] link_wd;
  logic             act_we;
  logic [IDX_W-1:0] act_wa;
  logic             act_wd;

  assign rd_addr = (req_t'(req_type) == REQ_ALLOC) ? free_head[IDX_W-1:0] : handle_index;
  assign rd_gen  = rd_gen_written ? rd_gen_raw : GEN_RESET;
  assign is_new  = (free_head == high_water);
  assign full    = is_new && (high_water == CNT_FULL);
  assign valid_c = (gen_q != '0) && (pgen_q == pool_gen) &&
                   ({1'b0, idx_q} < high_water) && rd_active && (rd_gen == gen_q);

  assign dp_stat.is_reset = (req_q == REQ_RESET);
  assign dp_stat.walk_end = (walk_cnt == high_water);

  always_comb begin
    gen_we  = 1'b0;
    gen_wa  = idx_q;
    gen_wd  = rd_gen + GEN_W'(1);
    link_we = 1'b0;
    link_wa = idx_q;
    link_wd = free_head;
    act_we  = 1'b0;
    act_wa  = idx_q;
    act_wd  = 1'b0;
    if (cmd.walk_step) begin
      gen_we  = 1'b1;
      gen_wa  = walk_cnt[IDX_W-1:0];
      gen_wd  = GEN_FRESH;
      link_we = 1'b1;
      link_wa = walk_cnt[IDX_W-1:0];
      link_wd = walk_cnt + CNT_W'(1);
      act_we  = 1'b1;
      act_wa  = walk_cnt[IDX_W-1:0];
    end else if (cmd.commit) begin
      if (req_q == REQ_ALLOC && !full) begin
        act_we = 1'b1;
        act_wa = free_head[IDX_W-1:0];
        act_wd = 1'b1;
      end else if (req_q == REQ_REMOVE && valid_c) begin
        gen_we  = 1'b1;
        link_we = 1'b1;
        act_we  = 1'b1;
      end
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (gen_we) begin
      gen_mem[gen_wa] <= gen_wd;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    if (cmd.load_req) begin
      rd_gen_raw <= gen_mem[rd_addr];
      rd_link    <= link_mem[rd_addr];
    end
  end

  // flags, request hold and registered flag read
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
      gen_written <= '0;
    end else begin
      if (act_we) begin
        slot_active[act_wa] <= act_wd;
      end
      if (gen_we) begin
        gen_written[gen_wa] <= 1'b1;
      end
    end
    if (cmd.load_req) begin
      req_q          <= req_t'(req_type);
      idx_q          <= handle_index;
      gen_q          <= handle_generation;
      pgen_q         <= handle_pool_generation;
      rd_active      <= slot_active[rd_addr];
      rd_gen_written <= gen_written[rd_addr];
    end
  end

  // pool registers
  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      high_water <= '0;
      pool_gen   <= GEN_RESET;
      walk_cnt   <= '0;
    end else begin
      if (cmd.load_req) begin
        walk_cnt <= '0;
      end else if (cmd.walk_step) begin
        walk_cnt <= walk_cnt + CNT_W'(1);
      end
      if (cmd.walk_done) begin
        free_head <= '0;
        pool_gen  <= pool_gen + GEN_W'(1);
      end else if (cmd.commit) begin
        if (req_q == REQ_ALLOC && !full) begin
          if (is_new) begin
            high_water <= high_water + CNT_W'(1);
            free_head  <= high_water + CNT_W'(1);
          end else begin
            free_head <= rd_link;
          end
        end else if (req_q == REQ_REMOVE && valid_c) begin
          free_head <= {1'b0, idx_q};
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.walk_done) begin
      out_index           <= '0;
      out_generation      <= '0;
      out_pool_generation <= '0;
      handle_ok           <= 1'b0;
      status              <= ST_OK;
    end else if (cmd.commit) begin
      out_index           <= '0;
      out_generation      <= '0;
      out_pool_generation <= '0;
      handle_ok           <= 1'b0;
      status              <= ST_OK;
      unique case (req_q)
        REQ_ALLOC: begin
          if (full) begin
            status <= ST_FULL;
          end else begin
            out_index           <= free_head[IDX_W-1:0];
            out_generation      <= rd_gen;
            out_pool_generation <= pool_gen;
          end
        end
        REQ_REMOVE, REQ_VALIDATE: begin
          handle_ok <= valid_c;
          status    <= valid_c ? ST_OK : ST_INVALID;
        end
        REQ_RESET: begin
          status <= ST_OK;
        end
        default: status <= ST_OK;
      endcase
    end
  end

endmodule
